// ----- sv/rgb_color_grade_unit_assert.svh -----
// Assertion macros for the color grade unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RGB_COLOR_GRADE_UNIT_ASSERT_SVH
`define RGB_COLOR_GRADE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCG_ASSERT(lbl, prop, msg)
`define RCG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/rcg_pkg.sv -----
// Shared types and constants of the color grade unit.
// No dependencies; compiled before all other files.
package rcg_pkg;

  localparam int PipeDepth = 10;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LIFT        = 3'd0,
    REG_CONTRAST    = 3'd1,
    REG_SATURATION  = 3'd2,
    REG_TINT_HUE    = 3'd3,
    REG_TINT_AMOUNT = 3'd4
  } rcg_reg_idx_t;

  // Grading coefficients derived from the register file
  typedef struct packed {
    logic [7:0]        lift;
    logic signed [10:0] cf;    // contrast factor, 256 = neutral
    logic [9:0]        sf;    // saturation factor, 256 = neutral
    logic [7:0]        ta;    // tint weight out of 256
    logic [2:0][7:0]   tint;  // tint color, index 0 = red
  } rcg_grade_t;

  typedef struct packed {
    logic busy;
    logic full;
  } rcg_pipe_stat_t;

endpackage

// ----- sv/rcg_in_if.sv -----
// Pixel input channel of the color grade unit.
// Depends on nothing but the handshake convention valid/ready.
interface rcg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_end_in;

  modport source (output valid, red_in, green_in, blue_in, frame_end_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, frame_end_in, output ready);
endinterface

// ----- sv/rcg_out_if.sv -----
// Pixel result channel of the color grade unit.
// Depends on nothing but the handshake convention valid/ready.
interface rcg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end_out;

  modport source (output valid, red_out, green_out, blue_out, frame_end_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end_out, output ready);
endinterface

// ----- sv/rcg_cfg_if.sv -----
// Register write channel of the color grade unit.
// Uses widths from rcg_pkg.
interface rcg_cfg_if;
  import rcg_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  idx;
  logic [CfgDataW-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ----- sv/rcg_cfg_regs.sv -----
// Register file and coefficient derivation of the color grade unit.
// Depends on rcg_pkg and rcg_cfg_if.
module rcg_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  rcg_cfg_if.sink            cfg_ch,
  output rcg_pkg::rcg_grade_t grade
);
  import rcg_pkg::*;

  localparam logic [23:0] RecipHundred = 24'd41944;    // 2^22 / 100, rounded up
  localparam logic [27:0] RecipTen     = 28'd52429;    // 2^19 / 10, rounded up
  localparam logic [9:0]  HueOffR = 10'd0;
  localparam logic [9:0]  HueOffG = 10'd240;
  localparam logic [9:0]  HueOffB = 10'd120;

  logic [7:0] lift_r, lift_nxt;
  logic [7:0] contrast_r, contrast_nxt;
  logic [7:0] sat_r, sat_nxt;
  logic [8:0] hue_r, hue_nxt;
  logic [6:0] amount_r, amount_nxt;

  logic [7:0]         con_mag;
  logic [23:0]        con_prod;
  logic [23:0]        sat_prod;
  logic signed [10:0] cf_r, cf_nxt;
  logic [9:0]         sf_r, sf_nxt;
  logic [7:0]         ta_r, ta_nxt;
  logic signed [5:0]  dist_r [3];
  logic signed [5:0]  dist_nxt [3];
  logic [7:0]         tint_r [3];
  logic [7:0]         tint_nxt [3];

  // Distance of the hue from the channel's full-on arc, clamped to +-30
  function automatic logic signed [5:0] hue_dist(input logic [9:0] k_raw);
    logic [9:0]         k;
    logic signed [10:0] a;
    logic signed [10:0] b;
    logic signed [10:0] m;
    begin
      if (k_raw >= 10'd720) begin
        k = k_raw - 10'd720;
      end else if (k_raw >= 10'd360) begin
        k = k_raw - 10'd360;
      end else begin
        k = k_raw;
      end
      a = $signed({1'b0, k}) - 11'sd90;
      b = 11'sd270 - $signed({1'b0, k});
      m = (a < b) ? a : b;
      if (m > 11'sd30) begin
        m = 11'sd30;
      end else if (m < -11'sd30) begin
        m = -11'sd30;
      end
      hue_dist = 6'(m);
    end
  endfunction

  // t = (1530 - 34*m) / 10, numerator always 510..2550
  function automatic logic [7:0] tint_level(input logic signed [5:0] m);
    logic signed [12:0] v;
    logic [27:0]        p;
    begin
      v = 13'sd1530 - (13'(m) * 13'sd34);
      p = 28'(v[11:0]) * RecipTen;
      tint_level = p[26:19];
    end
  endfunction

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    lift_nxt     = lift_r;
    contrast_nxt = contrast_r;
    sat_nxt      = sat_r;
    hue_nxt      = hue_r;
    amount_nxt   = amount_r;
    if (cfg_ch.valid) begin
      case (rcg_reg_idx_t'(cfg_ch.idx))
        REG_LIFT:        lift_nxt     = cfg_ch.data[7:0];
        REG_CONTRAST:    contrast_nxt = cfg_ch.data[7:0];
        REG_SATURATION:  sat_nxt      = cfg_ch.data[7:0];
        REG_TINT_HUE:    hue_nxt      = cfg_ch.data[8:0];
        REG_TINT_AMOUNT: amount_nxt   = cfg_ch.data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lift_r     <= 8'd0;
      contrast_r <= 8'd0;
      sat_r      <= 8'd100;
      hue_r      <= 9'd0;
      amount_r   <= 7'd0;
    end else begin
      lift_r     <= lift_nxt;
      contrast_r <= contrast_nxt;
      sat_r      <= sat_nxt;
      hue_r      <= hue_nxt;
      amount_r   <= amount_nxt;
    end
  end

  // First derivation step: contrast and saturation factors, tint weight, hue distances
  always_comb begin
    con_mag  = contrast_r[7] ? (8'd0 - contrast_r) : contrast_r;
    con_prod = 24'(con_mag) * RecipHundred;
    sat_prod = 24'(sat_r) * RecipHundred;
    // truncating division toward zero: apply the sign after dividing the magnitude
    cf_nxt = contrast_r[7] ? $signed(11'd256 - {1'b0, con_prod[23:14]})
                           : $signed(11'd256 + {1'b0, con_prod[23:14]});
    sf_nxt = sat_prod[23:14];
    // amt*102/100 = amt + amt/50
    if (amount_r >= 7'd100) begin
      ta_nxt = {1'b0, amount_r} + 8'd2;
    end else if (amount_r >= 7'd50) begin
      ta_nxt = {1'b0, amount_r} + 8'd1;
    end else begin
      ta_nxt = {1'b0, amount_r};
    end
    dist_nxt[0] = hue_dist({1'b0, hue_r} + HueOffR);
    dist_nxt[1] = hue_dist({1'b0, hue_r} + HueOffG);
    dist_nxt[2] = hue_dist({1'b0, hue_r} + HueOffB);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tint_nxt[i] = tint_level(dist_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    cf_r <= cf_nxt;
    sf_r <= sf_nxt;
    ta_r <= ta_nxt;
    for (int i = 0; i < 3; i++) begin
      dist_r[i] <= dist_nxt[i];
      tint_r[i] <= tint_nxt[i];
    end
  end

  always_comb begin
    grade.lift = lift_r;
    grade.cf   = cf_r;
    grade.sf   = sf_r;
    grade.ta   = ta_r;
    for (int i = 0; i < 3; i++) begin
      grade.tint[i] = tint_r[i];
    end
  end

endmodule

// ----- sv/rcg_pipe.sv -----
// Ten-stage pixel pipeline: lift, contrast, saturation, tint, clamp.
// Depends on rcg_pkg, rcg_in_if and rcg_out_if.
module rcg_pipe (
  input  logic                   clk,
  input  logic                   rst_n,
  rcg_in_if.sink                 in_ch,
  rcg_out_if.source              out_ch,
  input  rcg_pkg::rcg_grade_t    grade,
  output rcg_pkg::rcg_pipe_stat_t stat
);
  import rcg_pkg::*;

  localparam int Last = PipeDepth - 1;
  localparam logic signed [18:0] LumaR = 19'sd77;
  localparam logic signed [18:0] LumaG = 19'sd150;
  localparam logic signed [18:0] LumaB = 19'sd29;

  logic [PipeDepth-1:0] v_r, v_nxt, v_shift;
  logic [PipeDepth-1:0] fe_r, fe_nxt, fe_shift;
  logic [PipeDepth-1:0] ld;

  logic [7:0]         px0_r [3];
  logic [15:0]        lp1_r [3];     // lift product
  logic [15:0]        lp1_nxt [3];
  logic [7:0]         px2_r [3];
  logic [7:0]         px2_nxt [3];
  logic signed [19:0] cp3_r [3];     // contrast product
  logic signed [19:0] cp3_nxt [3];
  logic signed [9:0]  px4_r [3];
  logic signed [9:0]  px4_nxt [3];
  logic signed [9:0]  px5_r [3];
  logic signed [9:0]  lum5_r, lum5_nxt;
  logic signed [18:0] luma_sum;
  logic signed [20:0] sp6_r [3];     // saturation product
  logic signed [20:0] sp6_nxt [3];
  logic signed [9:0]  lum6_r;
  logic signed [12:0] px7_r [3];
  logic signed [12:0] px7_nxt [3];
  logic signed [22:0] ta8_r [3];     // pixel times (256 - ta)
  logic signed [22:0] ta8_nxt [3];
  logic [15:0]        tb8_r [3];     // tint times ta
  logic [15:0]        tb8_nxt [3];
  logic [7:0]         px9_r [3];
  logic [7:0]         px9_nxt [3];

  logic [7:0]         d255 [3];
  logic [16:0]        q255 [3];
  logic signed [8:0]  ctr [3];
  logic signed [10:0] dif [3];
  logic signed [9:0]  keep_w;
  logic signed [23:0] blend [3];
  logic signed [15:0] fl [3];

  // A stage loads when it is empty or its item moves on
  always_comb begin
    ld[Last] = !v_r[Last] || out_ch.ready;
    for (int k = Last - 1; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign v_shift  = {v_r[PipeDepth-2:0], in_ch.valid};
  assign fe_shift = {fe_r[PipeDepth-2:0], in_ch.frame_end_in};

  always_comb begin
    for (int k = 0; k < PipeDepth; k++) begin
      v_nxt[k]  = ld[k] ? v_shift[k] : v_r[k];
      fe_nxt[k] = ld[k] ? fe_shift[k] : fe_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fe_r <= fe_nxt;
  end

  always_comb begin
    keep_w = 10'sd256 - $signed({2'b00, grade.ta});
    luma_sum = 19'(px4_r[0]) * LumaR + 19'(px4_r[1]) * LumaG + 19'(px4_r[2]) * LumaB;
    lum5_nxt = 10'(luma_sum >>> 8);
    for (int i = 0; i < 3; i++) begin
      // lift: x*(255-lift), then /255 as (p + p/256 + 1)/256
      lp1_nxt[i] = 16'(px0_r[i]) * 16'(8'd255 - grade.lift);
      q255[i]    = 17'(lp1_r[i]) + 17'(lp1_r[i][15:8]) + 17'd1;
      d255[i]    = q255[i][15:8];
      px2_nxt[i] = grade.lift + d255[i];
      // contrast about 128
      ctr[i]     = $signed({1'b0, px2_r[i]}) - 9'sd128;
      cp3_nxt[i] = 20'(ctr[i]) * 20'(grade.cf);
      px4_nxt[i] = 10'(cp3_r[i] >>> 8) + 10'sd128;
      // saturation about luma
      dif[i]     = 11'(px5_r[i]) - 11'(lum5_r);
      sp6_nxt[i] = 21'(dif[i]) * $signed({11'd0, grade.sf});
      px7_nxt[i] = 13'(lum6_r) + 13'(sp6_r[i] >>> 8);
      // tint blend
      ta8_nxt[i] = 23'(px7_r[i]) * 23'(keep_w);
      tb8_nxt[i] = 16'(grade.tint[i]) * 16'(grade.ta);
      blend[i]   = 24'(ta8_r[i]) + $signed({8'd0, tb8_r[i]});
      fl[i]      = 16'(blend[i] >>> 8);
      if (fl[i] < 16'sd0) begin
        px9_nxt[i] = 8'd0;
      end else if (fl[i] > 16'sd255) begin
        px9_nxt[i] = 8'd255;
      end else begin
        px9_nxt[i] = fl[i][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      px0_r[0] <= in_ch.red_in;
      px0_r[1] <= in_ch.green_in;
      px0_r[2] <= in_ch.blue_in;
    end
    if (ld[5]) begin
      lum5_r <= lum5_nxt;
    end
    if (ld[6]) begin
      lum6_r <= lum5_r;
    end
    for (int i = 0; i < 3; i++) begin
      if (ld[1]) lp1_r[i] <= lp1_nxt[i];
      if (ld[2]) px2_r[i] <= px2_nxt[i];
      if (ld[3]) cp3_r[i] <= cp3_nxt[i];
      if (ld[4]) px4_r[i] <= px4_nxt[i];
      if (ld[5]) px5_r[i] <= px4_r[i];
      if (ld[6]) sp6_r[i] <= sp6_nxt[i];
      if (ld[7]) px7_r[i] <= px7_nxt[i];
      if (ld[8]) begin
        ta8_r[i] <= ta8_nxt[i];
        tb8_r[i] <= tb8_nxt[i];
      end
      if (ld[9]) px9_r[i] <= px9_nxt[i];
    end
  end

  assign in_ch.ready          = ld[0];
  assign out_ch.valid         = v_r[Last];
  assign out_ch.red_out       = px9_r[0];
  assign out_ch.green_out     = px9_r[1];
  assign out_ch.blue_out      = px9_r[2];
  assign out_ch.frame_end_out = fe_r[Last];

  assign stat.busy = |v_r;
  assign stat.full = &v_r;

endmodule

// ----- sv/rgb_color_grade_unit.sv -----
// Top level of the RGB888 color grade unit; depends on rcg_pkg, the three channel
// interfaces, rcg_cfg_regs and rcg_pipe. Each pixel runs lift, contrast, saturation
// and tint in that order and comes out clamped to 0..255 with its frame end flag.
// The unit takes one pixel per clock while in_ch.ready is high; each pixel passes the
// ten register stages of the pixel pipeline, and a held-off output stalls only as far
// back as the pipeline is full. Register writes are taken every cycle and reach the
// pixel path through the registers of rcg_cfg_regs, so they belong between frames.
`include "rgb_color_grade_unit_assert.svh"
module rgb_color_grade_unit (
  input logic        clk,
  input logic        rst_n,
  rcg_in_if.sink     in_ch,
  rcg_out_if.source  out_ch,
  rcg_cfg_if.sink    cfg_ch
);
  import rcg_pkg::*;

  rcg_grade_t     grade;
  rcg_pipe_stat_t stat;

  rcg_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .grade  (grade)
  );

  rcg_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .grade  (grade),
    .stat   (stat)
  );

  // input backs up only behind a result that is held off
  `RCG_ASSERT(a_stall_from_output, !in_ch.ready |-> (out_ch.valid && !out_ch.ready), "input stalled without output backpressure")
  `RCG_ASSERT(a_full_blocks_input, (stat.full && !out_ch.ready) |-> !in_ch.ready, "item taken into a full stalled pipeline")
  `RCG_ASSERT(a_empty_stays_empty, (!stat.busy && !(in_ch.valid && in_ch.ready)) |=> !out_ch.valid, "result without any item in flight")
  `RCG_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_ch.valid, "result valid right after reset")

endmodule

// ----- sim/rcg_grade_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the color grade unit: follows register writes, predicts each graded pixel
// and compares it with what leaves the result channel. Depends on rcg_pkg and the channel
// interfaces rcg_in_if, rcg_out_if and rcg_cfg_if.
module rcg_grade_checker (
  input  logic clk,
  input  logic rst_n,
  rcg_in_if    in_ch,
  rcg_out_if   out_ch,
  rcg_cfg_if   cfg_ch,
  output int   mismatches,
  output int   pending
);
  import rcg_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } rgb_item_t;

  // local copy of the grading registers
  logic [7:0] black_lift;
  logic [7:0] contrast_code;
  logic [7:0] sat_code;
  logic [8:0] hue_code;
  logic [6:0] tint_code;

  rgb_item_t graded_q[$];

  // tint level of one channel; offset in hue twelfths (R 0, G 8, B 4)
  function automatic longint tint_level(input longint offset, input longint hue);
    longint k;
    longint m;
    k = (30 * offset + hue) % 360;
    m = (k - 90 < 270 - k) ? k - 90 : 270 - k;
    if (m > 30) m = 30;
    if (m < -30) m = -30;
    return (1530 - 34 * m) / 10;
  endfunction

  function automatic logic [7:0] clamp_byte(input longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic rgb_item_t grade_pixel(input rgb_item_t px_in);
    longint c [3];
    longint tc [3];
    longint lift;
    longint con;
    longint sat;
    longint ta;
    longint cf;
    longint sf;
    longint lum;
    rgb_item_t res;
    c[0] = longint'(px_in.red);
    c[1] = longint'(px_in.green);
    c[2] = longint'(px_in.blue);
    lift = longint'(black_lift);
    con  = longint'($signed(contrast_code));
    sat  = longint'(sat_code);
    ta   = longint'(tint_code) * 102 / 100;
    if (lift != 0)
      for (int i = 0; i < 3; i++) c[i] = lift + c[i] * (255 - lift) / 255;
    if (con != 0) begin
      cf = 256 + con * 256 / 100;   // goes negative below -100: inverts about 128
      for (int i = 0; i < 3; i++) c[i] = (((c[i] - 128) * cf) >>> 8) + 128;
    end
    if (sat != 100) begin
      sf  = sat * 256 / 100;
      lum = (77 * c[0] + 150 * c[1] + 29 * c[2]) >>> 8;
      for (int i = 0; i < 3; i++) c[i] = lum + (((c[i] - lum) * sf) >>> 8);
    end
    if (ta != 0) begin
      tc[0] = tint_level(0, longint'(hue_code));
      tc[1] = tint_level(8, longint'(hue_code));
      tc[2] = tint_level(4, longint'(hue_code));
      for (int i = 0; i < 3; i++) c[i] = (c[i] * (256 - ta) + tc[i] * ta) >>> 8;
    end
    res.red       = clamp_byte(c[0]);
    res.green     = clamp_byte(c[1]);
    res.blue      = clamp_byte(c[2]);
    res.frame_end = px_in.frame_end;
    return res;
  endfunction

  function automatic void log_error(input string what, input rgb_item_t want,
                                    input rgb_item_t got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("%0t: %s: expected r=%0d g=%0d b=%0d fe=%0b, got r=%0d g=%0d b=%0d fe=%0b",
               $realtime, what, want.red, want.green, want.blue, want.frame_end,
               got.red, got.green, got.blue, got.frame_end);
  endfunction

  always @(posedge clk) begin : watch
    rgb_item_t got;
    rgb_item_t want;
    if (!rst_n) begin
      black_lift    = 8'd0;
      contrast_code = 8'd0;
      sat_code      = 8'd100;
      hue_code      = 9'd0;
      tint_code     = 7'd0;
      graded_q.delete();
      mismatches    = 0;
      pending       = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.red_out, out_ch.green_out, out_ch.blue_out, out_ch.frame_end_out};
        if (graded_q.size() == 0) begin
          log_error("pixel with none pending", '0, got);
        end else begin
          want = graded_q.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.frame_end !== want.frame_end)
            log_error("pixel mismatch", want, got);
        end
      end
      if (in_ch.valid && in_ch.ready)
        graded_q.push_back(grade_pixel({in_ch.red_in, in_ch.green_in, in_ch.blue_in,
                                        in_ch.frame_end_in}));
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.idx)
          REG_LIFT:        black_lift    = cfg_ch.data[7:0];
          REG_CONTRAST:    contrast_code = cfg_ch.data[7:0];
          REG_SATURATION:  sat_code      = cfg_ch.data[7:0];
          REG_TINT_HUE:    hue_code      = cfg_ch.data[8:0];
          REG_TINT_AMOUNT: tint_code     = cfg_ch.data[6:0];
          default: ;   // unused index, write dropped
        endcase
      end
      pending = graded_q.size();
    end
  end

endmodule

// ----- sim/rgb_color_grade_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for rgb_color_grade_unit: clock, reset, pixel and register stimulus, verdict.
// Depends on rcg_pkg, the channel interfaces, the unit itself and rcg_grade_checker.
module rgb_color_grade_unit_tb;
  import rcg_pkg::*;

  localparam int CycleLimit     = 400000;
  localparam int HoldCycles     = 300;
  localparam int IdlePct        = 9;
  localparam int RandomPhases   = 12;
  localparam int PixelsPerPhase = 105;
  localparam int HoldPhase      = 3;
  localparam int CalmPhase      = 6;
  localparam logic [CfgIdxW-1:0] IdxSpareLo = 3'd5;
  localparam logic [CfgIdxW-1:0] IdxSpareHi = 3'd7;

  // {frame_end, red, green, blue}
  localparam logic [24:0] CornerPx [8] = '{
    25'h0000000, 25'h1FFFFFF, 25'h0FF0000, 25'h100FF00,
    25'h00000FF, 25'h1808080, 25'h001FE7F, 25'h1FE0180
  };

  logic clk;
  logic rst_n;
  logic calm     = 1'b0;  // no random idling on either side
  logic hold_req = 1'b0;  // asks the receiver for a long hold-off
  int   mismatches;
  int   pending;
  int   cycles = 0;

  rcg_in_if  in_ch();
  rcg_out_if out_ch();
  rcg_cfg_if cfg_ch();

  rgb_color_grade_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rcg_grade_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // valid stays high between back-to-back items
  task automatic send_pixel(input logic [24:0] px);
    if (!calm)
      while ($urandom_range(99) < IdlePct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    in_ch.valid        <= 1'b1;
    in_ch.frame_end_in <= px[24];
    in_ch.red_in       <= px[23:16];
    in_ch.green_in     <= px[15:8];
    in_ch.blue_in      <= px[7:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_corners();
    for (int i = 0; i < 8; i++) send_pixel(CornerPx[i]);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PipeDepth) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // only with the pipeline empty; waits for the new values to settle before pixels follow
  task automatic apply_grade(input logic [CfgDataW-1:0] lift, input logic [CfgDataW-1:0] con,
                             input logic [CfgDataW-1:0] sat, input logic [CfgDataW-1:0] hue,
                             input logic [CfgDataW-1:0] amt, input logic spare);
    drain();
    write_reg(REG_LIFT, lift);
    write_reg(REG_CONTRAST, con);
    write_reg(REG_SATURATION, sat);
    write_reg(REG_TINT_HUE, hue);
    write_reg(REG_TINT_AMOUNT, amt);
    if (spare)
      for (int k = IdxSpareLo; k <= IdxSpareHi; k++)
        write_reg(CfgIdxW'(k), CfgDataW'($urandom_range(511)));
    cfg_ch.valid <= 1'b0;
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.red_in       <= 8'd0;
    in_ch.green_in     <= 8'd0;
    in_ch.blue_in      <= 8'd0;
    in_ch.frame_end_in <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.idx         <= REG_LIFT;
    cfg_ch.data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings pass pixels through
    send_corners();
    // full lift, contrast below -100, greyscale, hue past 359, amount past 100
    apply_grade(9'd255, 9'h080, 9'd0, 9'd511, 9'd127, 1'b1);
    send_corners();
    apply_grade(9'd0, 9'd127, 9'd255, 9'd359, 9'd100, 1'b0);
    send_corners();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      // bit 8 of the 8-bit registers is random too and must be dropped
      apply_grade(($urandom_range(3) == 0) ? 9'd0   : 9'($urandom_range(511)),
                  ($urandom_range(3) == 0) ? 9'd0   : 9'($urandom_range(511)),
                  ($urandom_range(3) == 0) ? 9'd100 : 9'($urandom_range(511)),
                  9'($urandom_range(511)),
                  ($urandom_range(3) == 0) ? 9'd0   : 9'($urandom_range(511)),
                  $urandom_range(3) == 0);
      calm = (ph == CalmPhase);
      for (int n = 0; n < PixelsPerPhase; n++) begin
        if (ph == HoldPhase && n == 30) hold_req = 1'b1;
        send_pixel({1'($urandom_range(15) == 0), rand_byte(), rand_byte(), rand_byte()});
      end
    end
    calm = 1'b0;

    drain();
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/rcg_pkg.sv
sv/rcg_in_if.sv
sv/rcg_out_if.sv
sv/rcg_cfg_if.sv
sv/rcg_cfg_regs.sv
sv/rcg_pipe.sv
sv/rgb_color_grade_unit.sv
sim/rcg_grade_checker.sv
sim/rgb_color_grade_unit_tb.sv
